### sv/apu_pkg.sv
// shared types, constants and the reciprocal table for the alpha premultiply unit
// no dependencies
package apu_pkg;

    localparam int unsigned NUM_COLORS  = 3;
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned CCNT_W      = 2;
    localparam int unsigned PROD_W      = 2 * CHAN_W;
    localparam logic [CCNT_W-1:0] CCNT_RESET = 2'd3;
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
    localparam logic [CHAN_W-1:0] ALPHA_ZERO = 8'd0;

    typedef enum logic {
        OP_PREMULTIPLY   = 1'b0,
        OP_UNPREMULTIPLY = 1'b1
    } t_op;

    typedef logic [NUM_COLORS-1:0][CHAN_W-1:0] t_colors;
    typedef logic [NUM_COLORS-1:0][PROD_W-1:0] t_products;

    // floor(255 / a); an alpha of zero gives 0
    function automatic logic [CHAN_W-1:0] recip255(input logic [CHAN_W-1:0] a);
        logic [CHAN_W-1:0] r;
        r = '0;
        case (a) inside
            8'd1:            r = 8'd255;
            8'd2:            r = 8'd127;
            8'd3:            r = 8'd85;
            8'd4:            r = 8'd63;
            8'd5:            r = 8'd51;
            8'd6:            r = 8'd42;
            8'd7:            r = 8'd36;
            8'd8:            r = 8'd31;
            8'd9:            r = 8'd28;
            8'd10:           r = 8'd25;
            8'd11:           r = 8'd23;
            8'd12:           r = 8'd21;
            8'd13:           r = 8'd19;
            8'd14:           r = 8'd18;
            8'd15:           r = 8'd17;
            [8'd16:8'd17]:   r = 8'd15;
            8'd18:           r = 8'd14;
            8'd19:           r = 8'd13;
            [8'd20:8'd21]:   r = 8'd12;
            [8'd22:8'd23]:   r = 8'd11;
            [8'd24:8'd25]:   r = 8'd10;
            [8'd26:8'd28]:   r = 8'd9;
            [8'd29:8'd31]:   r = 8'd8;
            [8'd32:8'd36]:   r = 8'd7;
            [8'd37:8'd42]:   r = 8'd6;
            [8'd43:8'd51]:   r = 8'd5;
            [8'd52:8'd63]:   r = 8'd4;
            [8'd64:8'd85]:   r = 8'd3;
            [8'd86:8'd127]:  r = 8'd2;
            [8'd128:8'd255]: r = 8'd1;
            default:         r = '0;
        endcase
        return r;
    endfunction

endpackage

### sv/alpha_premultiply_unit.sv
// alpha premultiply / unpremultiply unit, three register stages, one pixel per clock unless the receiver stalls
// depends on apu_pkg
//
// usage:
//   slave stream takes one pixel per transfer: tdata holds the colour bytes a, b, c
//   and alpha, tuser the operation (0 premultiply, 1 unpremultiply), tlast the row end.
//   master stream gives the processed pixel with alpha and tlast unchanged.
//   premultiply gives floor(c*a/255); unpremultiply multiplies by floor(255/a) and
//   saturates at 255, passing the pixel unchanged for alpha 0 or 255.
//   i_cfg_we / i_cfg_data set how many colour channels are processed (0..3); the
//   rest pass through. write it only while the pipe is empty.
// path: an input transfer passes the stage 1, 2 and 3 registers to the master side.
// throughput: one pixel per cycle unless the receiver stalls, set by the three-stage pipe
//   (lookup, multiply, scale/saturate), each stage with its own valid bit.
// reset: synchronous, active low; all stages empty, channel count back to 3.
// stall: each stage holds while the next one is full and blocked, so bubbles close
//   up and nothing is lost or repeated; tready on the slave side falls only when
//   all three stages are full and the receiver holds tready low.
module alpha_premultiply_unit
    import apu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CCNT_W-1:0]   i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,   // color_a, color_b, color_c, alpha_in
    input  logic                s_axis_tuser,   // operation
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,   // out_a, out_b, out_c, alpha_out
    output logic                m_axis_tlast
);

    logic [CCNT_W-1:0] r_color_channels;

    // stage 1: captured pixel, multiplier factor, per-channel enables
    logic                  r_s1_valid;
    t_colors               r_s1_col;
    logic [CHAN_W-1:0]     r_s1_alpha;
    logic [CHAN_W-1:0]     r_s1_factor;
    logic [NUM_COLORS-1:0] r_s1_active;
    t_op                   r_s1_op;
    logic                  r_s1_last;

    // stage 2: products
    logic                  r_s2_valid;
    t_colors               r_s2_col;
    t_products             r_s2_prod;
    logic [CHAN_W-1:0]     r_s2_alpha;
    logic [NUM_COLORS-1:0] r_s2_active;
    t_op                   r_s2_op;
    logic                  r_s2_last;

    // stage 3: output register
    logic                  r_s3_valid;
    t_colors               r_s3_col;
    logic [CHAN_W-1:0]     r_s3_alpha;
    logic                  r_s3_last;

    logic s1_ready, s2_ready, s3_ready;
    logic s1_load, s2_load, s3_load;

    t_op                   n_s1_op;
    logic [CHAN_W-1:0]     n_s1_factor;
    logic [NUM_COLORS-1:0] n_s1_active;
    logic                  bypass;
    t_colors               n_s3_col;

    assign s3_ready = !r_s3_valid || m_axis_tready;
    assign s2_ready = !r_s2_valid || s3_ready;
    assign s1_ready = !r_s1_valid || s2_ready;

    assign s1_load = s_axis_tvalid && s1_ready;
    assign s2_load = r_s1_valid && s2_ready;
    assign s3_load = r_s2_valid && s3_ready;

    assign s_axis_tready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_channels <= CCNT_RESET;
        end else if (i_cfg_we) begin
            r_color_channels <= i_cfg_data;
        end
    end

    always_comb begin
        n_s1_op = t_op'(s_axis_tuser);
        bypass  = (n_s1_op == OP_UNPREMULTIPLY) &&
                  ((s_axis_tdata[31:24] == ALPHA_ZERO) || (s_axis_tdata[31:24] == CHAN_MAX));
        n_s1_factor = (n_s1_op == OP_PREMULTIPLY) ? s_axis_tdata[31:24]
                                                  : recip255(s_axis_tdata[31:24]);
        for (int i = 0; i < NUM_COLORS; i++) begin
            n_s1_active[i] = !bypass && (CCNT_W'(i) < r_color_channels);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_col    <= s_axis_tdata[23:0];
            r_s1_alpha  <= s_axis_tdata[31:24];
            r_s1_factor <= n_s1_factor;
            r_s1_active <= n_s1_active;
            r_s1_op     <= n_s1_op;
            r_s1_last   <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            for (int i = 0; i < NUM_COLORS; i++) begin
                r_s2_prod[i] <= PROD_W'(r_s1_col[i]) * PROD_W'(r_s1_factor);
            end
            r_s2_col    <= r_s1_col;
            r_s2_alpha  <= r_s1_alpha;
            r_s2_active <= r_s1_active;
            r_s2_op     <= r_s1_op;
            r_s2_last   <= r_s1_last;
        end
    end

    // x/255 as (x + 1 + (x >> 8)) >> 8, exact for every 8x8 product
    always_comb begin
        logic [PROD_W:0] sum;
        for (int i = 0; i < NUM_COLORS; i++) begin
            sum = {1'b0, r_s2_prod[i]} + (PROD_W+1)'(1)
                + (PROD_W+1)'(r_s2_prod[i][PROD_W-1:CHAN_W]);
            if (!r_s2_active[i]) begin
                n_s3_col[i] = r_s2_col[i];
            end else if (r_s2_op == OP_PREMULTIPLY) begin
                n_s3_col[i] = sum[PROD_W-1:CHAN_W];
            end else if (r_s2_prod[i] > PROD_W'(CHAN_MAX)) begin
                n_s3_col[i] = CHAN_MAX;
            end else begin
                n_s3_col[i] = r_s2_prod[i][CHAN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_ready) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_load) begin
            r_s3_col   <= n_s3_col;
            r_s3_alpha <= r_s2_alpha;
            r_s3_last  <= r_s2_last;
        end
    end

    assign m_axis_tvalid = r_s3_valid;
    assign m_axis_tdata  = {r_s3_alpha, r_s3_col};
    assign m_axis_tlast  = r_s3_last;

endmodule

### bench/alpha_premultiply_unit_tb.sv
// self-checking bench for alpha_premultiply_unit: directed and random pixel streams
// with bursty idling on both sides, checked against an in-bench pixel predictor
// depends on apu_pkg and alpha_premultiply_unit
module alpha_premultiply_unit_tb;
    import apu_pkg::*;

    localparam int PIPE_DEPTH     = 3;
    localparam int RX_HOLD_CYCLES = 40;
    localparam int PHASE_PIXELS   = 300;

    typedef struct packed {
        logic                row_end;
        logic [CHAN_W-1:0]   alpha;
        t_colors             colors;
    } t_result_pixel;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CCNT_W-1:0]   i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata;   // color_a, color_b, color_c, alpha_in
    logic                s_axis_tuser;   // operation
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [31:0]         m_axis_tdata;   // out_a, out_b, out_c, alpha_out
    logic                m_axis_tlast;

    t_result_pixel       pending_pixels[$];
    logic [CCNT_W-1:0]   channel_count = CCNT_RESET;
    bit                  tx_idle_en = 1'b1;
    bit                  rx_idle_en = 1'b1;
    int                  hold_req_cnt = 0;
    int                  hold_served_cnt = 0;
    int                  hold_left = 0;
    int                  rx_gap_left = 0;
    int                  errors = 0;
    int                  n_premult = 0;
    int                  n_unpremult = 0;
    int                  n_checked = 0;

    alpha_premultiply_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected output pixel for the current channel count
    function automatic t_result_pixel apply_alpha_op(input t_op op, input t_colors colors,
                                                     input logic [CHAN_W-1:0] alpha,
                                                     input logic row_end);
        t_result_pixel res;
        int unsigned   prod;
        int unsigned   recip;
        res.row_end = row_end;
        res.alpha   = alpha;
        res.colors  = colors;
        if (op == OP_PREMULTIPLY) begin
            for (int i = 0; i < NUM_COLORS; i++) begin
                if (i < channel_count) begin
                    prod = int'(colors[i]) * int'(alpha);
                    res.colors[i] = CHAN_W'(prod / 255);
                end
            end
        end else if (alpha != 0 && alpha != 255) begin
            recip = 255 / int'(alpha);
            for (int i = 0; i < NUM_COLORS; i++) begin
                if (i < channel_count) begin
                    prod = int'(colors[i]) * recip;
                    res.colors[i] = (prod > 255) ? CHAN_MAX : CHAN_W'(prod);
                end
            end
        end
        return res;
    endfunction

    task automatic send_pixel(input t_op op, input t_colors colors,
                              input logic [CHAN_W-1:0] alpha, input logic row_end);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {alpha, colors};
        s_axis_tuser  <= op;
        s_axis_tlast  <= row_end;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_pixels.push_back(apply_alpha_op(op, colors, alpha, row_end));
        if (op == OP_PREMULTIPLY) n_premult++;
        else n_unpremult++;
    endtask

    task automatic send_random_pixel();
        t_colors           colors;
        logic [CHAN_W-1:0] alpha;
        for (int i = 0; i < NUM_COLORS; i++) colors[i] = CHAN_W'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0:       alpha = ALPHA_ZERO;
            1:       alpha = CHAN_MAX;
            2:       alpha = CHAN_W'($urandom_range(1, 16));
            default: alpha = CHAN_W'($urandom_range(0, 255));
        endcase
        send_pixel(t_op'($urandom_range(0, 1)), colors, alpha, $urandom_range(0, 7) == 0);
    endtask

    // stop sending and let every outstanding transfer come out of the pipe
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic set_channel_count(input logic [CCNT_W-1:0] count);
        wait_for_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= count;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        channel_count = count;
    endtask

    task automatic test_reset_defaults();
        send_pixel(OP_PREMULTIPLY,   {8'd0,   8'd0,   8'd0},   8'd0,   1'b0);
        send_pixel(OP_PREMULTIPLY,   {8'd255, 8'd255, 8'd255}, 8'd255, 1'b1);
        send_pixel(OP_PREMULTIPLY,   {8'd1,   8'd128, 8'd255}, 8'd0,   1'b0);
        send_pixel(OP_PREMULTIPLY,   {8'd1,   8'd128, 8'd255}, 8'd1,   1'b0);
        send_pixel(OP_PREMULTIPLY,   {8'd50,  8'd100, 8'd200}, 8'd128, 1'b0);
        // alpha 0 and 255 leave the pixel alone
        send_pixel(OP_UNPREMULTIPLY, {8'd30,  8'd20,  8'd10},  8'd0,   1'b0);
        send_pixel(OP_UNPREMULTIPLY, {8'd30,  8'd20,  8'd10},  8'd255, 1'b1);
        // unpremultiply over small and large alpha, with saturation on small alpha
        send_pixel(OP_UNPREMULTIPLY, {8'd255, 8'd2,   8'd1},   8'd1,   1'b0);
        send_pixel(OP_UNPREMULTIPLY, {8'd255, 8'd100, 8'd0},   8'd254, 1'b0);
        send_pixel(OP_UNPREMULTIPLY, {8'd127, 8'd50,  8'd40},  8'd127, 1'b0);
        send_pixel(OP_UNPREMULTIPLY, {8'd42,  8'd43,  8'd200}, 8'd42,  1'b0);
        send_pixel(OP_PREMULTIPLY,   {8'hFF,  8'hAA,  8'h55},  8'hAA,  1'b1);
        wait_for_drain();
    endtask

    task automatic test_channel_counts();
        for (int n = 0; n <= 3; n++) begin
            set_channel_count(CCNT_W'(n));
            send_pixel(OP_PREMULTIPLY,   {8'd100, 8'd150, 8'd200}, 8'd100, 1'b1);
            send_pixel(OP_UNPREMULTIPLY, {8'd80,  8'd70,  8'd60},  8'd50,  1'b0);
        end
        wait_for_drain();
    endtask

    // receiver holds off long enough for the pipe to fill and stall the input
    task automatic test_full_pipe_stall();
        tx_idle_en = 1'b0;
        hold_req_cnt <= hold_req_cnt + 1;
        repeat (30) send_random_pixel();
        wait_for_drain();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_pixels();
        logic [CCNT_W-1:0] counts[5];
        counts = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3};
        for (int p = 0; p < 5; p++) begin
            set_channel_count(counts[p]);
            if (p == 4) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            repeat (PHASE_PIXELS) send_random_pixel();
        end
        wait_for_drain();
    endtask

    // receiver side: long hold-offs on request, otherwise random stall bursts while idling is enabled
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_served_cnt != hold_req_cnt) begin
            m_axis_tready   <= 1'b0;
            hold_served_cnt <= hold_req_cnt;
            hold_left       <= RX_HOLD_CYCLES - 1;
        end else if (rx_gap_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap_left   <= rx_gap_left - 1;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            rx_gap_left   <= $urandom_range(0, 10);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic report_field(input string field, input int unsigned want,
                                input int unsigned got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_result_pixel want;
        t_result_pixel got;
        bit            bad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tlast, m_axis_tdata};
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                bad  = 1'b0;
                for (int i = 0; i < NUM_COLORS; i++) begin
                    if (got.colors[i] !== want.colors[i]) begin
                        report_field($sformatf("out_%0d", i), want.colors[i], got.colors[i]);
                        bad = 1'b1;
                    end
                end
                if (got.alpha !== want.alpha) begin
                    report_field("alpha_out", want.alpha, got.alpha);
                    bad = 1'b1;
                end
                if (got.row_end !== want.row_end) begin
                    report_field("row_end_out", want.row_end, got.row_end);
                    bad = 1'b1;
                end
                if (bad) errors++;
                n_checked++;
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_channel_counts();
        test_full_pipe_stall();
        test_random_pixels();

        $display("checked %0d pixels: %0d premultiply, %0d unpremultiply",
                 n_checked, n_premult, n_unpremult);
        $display("channel counts 0 to 3, long output stall and bursty idling on both sides");
        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("timed out with %0d results outstanding", pending_pixels.size());
        $display("FAIL");
        $finish;
    end

endmodule
